// File: rtl/ecas_pkg.sv
// ----------------------------------------------------------------------------
// ecas_pkg: shared types and constants
// Operation codes, border modes, register indexes and field widths for the
// one-dimensional cellular automaton row.
// ----------------------------------------------------------------------------
package ecas_pkg;

  localparam int MAX_CELLS_DEF = 256;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 8;
  localparam int STEPS_W   = 8;
  localparam int RULE_W    = 8;
  localparam int BORDER_W  = 2;
  localparam int HAB_W     = 9;
  localparam int GEN_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW    = 9;
  localparam int IN_DW     = 24;
  localparam int OUT_DW    = 40;

  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ    = 2'd1;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

  localparam logic [BORDER_W-1:0] BORDER_WRAP  = 2'd0;
  localparam logic [BORDER_W-1:0] BORDER_DEAD  = 2'd1;
  localparam logic [BORDER_W-1:0] BORDER_ALIVE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RULE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAB    = 2'd2;

  localparam logic [RULE_W-1:0]   RULE_RST   = 8'd30;
  localparam logic [BORDER_W-1:0] BORDER_RST = BORDER_WRAP;
  localparam logic [HAB_W-1:0]    HAB_RST    = 9'd256;

  typedef struct packed {
    logic [RULE_W-1:0]   rule;
    logic [BORDER_W-1:0] border;
  } ecas_cfg_t;

endpackage

// File: rtl/elementary_cellular_automaton_step.sv
// ----------------------------------------------------------------------------
// elementary_cellular_automaton_step: one-row elementary cellular automaton
// Holds the cell row, serves write, read and advance transactions.
// ----------------------------------------------------------------------------
// The row sits in flip-flops and a single generation unit computes a whole
// new row per cycle, reused under a small sequencer. A write, read or unused
// op returns its result in the cycle after acceptance. An advance of S > 0
// generations runs the row through the unit once per generation and gives
// its result on leaving the run state; zero steps completes like a read.
// in_tready is low while an advance runs and while an undelivered result
// cannot be replaced. There is no clearing pass: reset clears the row at once.
module elementary_cellular_automaton_step #(
  parameter int MAX_CELLS = ecas_pkg::MAX_CELLS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [1:0] op, [9:2] cell_index, [10] cell_value, [18:11] steps, rest zero
  input  logic [ecas_pkg::IN_DW-1:0]    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] read_value, [32:1] generation_count, rest zero
  output logic [ecas_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                          cfg_we,
  input  logic [ecas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ecas_pkg::CFG_DW-1:0]   cfg_wdata
);
  import ecas_pkg::*;

  localparam int NW = $clog2(MAX_CELLS + 1);
  localparam int IW = $clog2(MAX_CELLS);
  localparam int CW = (NW > HAB_W) ? NW : HAB_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_CELLS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic                 state_r, state_nxt;
  logic [STEPS_W-1:0]   step_cnt_r, step_cnt_nxt;
  logic [GEN_W-1:0]     gen_cnt_r, gen_cnt_nxt;
  logic [MAX_CELLS-1:0] row_r, row_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 rd_val_r, rd_val_nxt;
  logic [GEN_W-1:0]     out_gen_r, out_gen_nxt;

  ecas_cfg_t            cfg_r;
  logic [HAB_W-1:0]     hab_r;

  logic [MAX_CELLS-1:0] row_gen;
  logic [CW-1:0]        hab_ext;
  logic [CW-1:0]        n_ext;
  logic [NW-1:0]        n_cells;
  logic [CW-1:0]        idx_ext;
  logic                 idx_ok;
  logic                 in_acc;
  logic [OP_W-1:0]      in_op;
  logic [IDX_W-1:0]     in_idx;
  logic                 in_val;
  logic [STEPS_W-1:0]   in_steps;
  logic [GEN_W-1:0]     gen_inc;

  assign in_op    = in_tdata[1:0];
  assign in_idx   = in_tdata[9:2];
  assign in_val   = in_tdata[10];
  assign in_steps = in_tdata[18:11];

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - GEN_W - 1)'(0), out_gen_r, rd_val_r};

  // size in use clamped to 1..MAX_CELLS
  assign hab_ext = CW'(hab_r);
  always_comb begin
    if (hab_ext == '0) begin
      n_ext = CW'(1);
    end else if (hab_ext > MAX_C) begin
      n_ext = MAX_C;
    end else begin
      n_ext = hab_ext;
    end
  end
  assign n_cells = n_ext[NW-1:0];

  assign idx_ext = CW'(in_idx);
  assign idx_ok  = (idx_ext < n_ext);
  assign gen_inc = (gen_cnt_r == '1) ? gen_cnt_r : gen_cnt_r + GEN_W'(1);

  ecas_gen #(
    .MAX_CELLS (MAX_CELLS),
    .NW        (NW)
  ) u_gen (
    .cfg      (cfg_r),
    .n_cells  (n_cells),
    .row      (row_r),
    .row_next (row_gen)
  );

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    gen_cnt_nxt   = gen_cnt_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_val_nxt    = rd_val_r;
    out_gen_nxt   = out_gen_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_val_nxt  = 1'b0;
          out_gen_nxt = gen_cnt_r;
          case (in_op)
            OP_WRITE: begin
              if (idx_ok) begin
                row_nxt[idx_ext[IW-1:0]] = in_val;
              end
              out_valid_nxt = 1'b1;
            end
            OP_READ: begin
              rd_val_nxt    = idx_ok && row_r[idx_ext[IW-1:0]];
              out_valid_nxt = 1'b1;
            end
            OP_ADVANCE: begin
              if (in_steps == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                step_cnt_nxt = in_steps;
                state_nxt    = S_RUN;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        row_nxt      = row_gen;
        gen_cnt_nxt  = gen_inc;
        step_cnt_nxt = step_cnt_r - STEPS_W'(1);
        if (step_cnt_r == STEPS_W'(1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          rd_val_nxt    = 1'b0;
          out_gen_nxt   = gen_inc;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      gen_cnt_r   <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r.rule   <= RULE_RST;
      cfg_r.border <= BORDER_RST;
      hab_r        <= HAB_RST;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      gen_cnt_r   <= gen_cnt_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_RULE:   cfg_r.rule   <= cfg_wdata[RULE_W-1:0];
          REG_BORDER: cfg_r.border <= cfg_wdata[BORDER_W-1:0];
          REG_HAB:    hab_r        <= cfg_wdata[HAB_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_val_r  <= rd_val_nxt;
    out_gen_r <= out_gen_nxt;
  end

  // no result is pending while an advance runs
  a_run_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> !out_valid_r)
    else $error("result pending during advance");

  // the last generation of an advance presents its result next cycle
  a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN && step_cnt_r == STEPS_W'(1) |=> out_valid_r && state_r == S_IDLE)
    else $error("advance did not complete");

  // generation counter never goes backward
  a_gen_mono: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |=> gen_cnt_r >= $past(gen_cnt_r))
    else $error("generation counter decreased");

endmodule

// File: rtl/ecas_gen.sv
// ----------------------------------------------------------------------------
// ecas_gen: one-generation update unit
// Computes the next row from the current one under the rule and border mode;
// cells at or beyond the count in use keep their value.
// ----------------------------------------------------------------------------
module ecas_gen #(
  parameter int MAX_CELLS = ecas_pkg::MAX_CELLS_DEF,
  parameter int NW        = $clog2(MAX_CELLS + 1)
) (
  input  ecas_pkg::ecas_cfg_t   cfg,
  input  logic [NW-1:0]         n_cells,
  input  logic [MAX_CELLS-1:0]  row,
  output logic [MAX_CELLS-1:0]  row_next
);
  import ecas_pkg::*;

  localparam int IW = $clog2(MAX_CELLS);

  logic [NW-1:0] n_m1;
  logic          wrap;
  logic          fixed_val;
  logic          out_left;
  logic          out_right;

  assign n_m1      = n_cells - NW'(1);
  assign wrap      = (cfg.border == BORDER_WRAP);
  assign fixed_val = (cfg.border == BORDER_ALIVE);
  // neighbor seen past the left end is the last cell in use when wrapping
  assign out_left  = wrap ? row[n_m1[IW-1:0]] : fixed_val;
  assign out_right = wrap ? row[0] : fixed_val;

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    logic       lft;
    logic       rgt;
    logic       is_last;
    logic [2:0] hood;

    assign is_last = (NW'(i) == n_m1);
    if (i == 0) begin : g_first
      assign lft = out_left;
    end else begin : g_mid_l
      assign lft = row[i-1];
    end
    if (i == MAX_CELLS - 1) begin : g_end
      assign rgt = out_right;
    end else begin : g_mid_r
      assign rgt = is_last ? out_right : row[i+1];
    end
    assign hood        = {lft, row[i], rgt};
    assign row_next[i] = (NW'(i) < n_cells) ? cfg.rule[hood] : row[i];
  end

endmodule

// File: tb/tb_elementary_cellular_automaton_step.sv
// ----------------------------------------------------------------------------
// tb_elementary_cellular_automaton_step: self-checking bench for the row block
// Drives write, read and advance transactions over the input stream, predicts
// every result with a local model of the cell row and generation counter, and
// compares each delivered result in order. A directed table comes first, then
// random phases under different rules, border modes, sizes and idle patterns.
// ----------------------------------------------------------------------------
module tb_elementary_cellular_automaton_step;
  import ecas_pkg::*;

  localparam logic [OP_W-1:0]     OP_UNUSED     = 2'd3;
  localparam logic [BORDER_W-1:0] BORDER_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int LONG_HOLD       = 400;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int TAIL_CYCLES     = 300;

  typedef struct packed {
    logic             rd;
    logic [GEN_W-1:0] gen;
  } ca_result_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [OP_W-1:0]      op;
    logic [IDX_W-1:0]     idx;
    logic                 val;
    logic [STEPS_W-1:0]   steps;
    bit                   typed;
    ca_result_t           res;
    logic [CFG_IDX_W-1:0] sel;
    logic [CFG_DW-1:0]    value;
  } dir_row_t;

  typedef struct {
    logic [RULE_W-1:0]   rule;
    logic [BORDER_W-1:0] border;
    logic [HAB_W-1:0]    hab;
    bit                  pick_random;
  } phase_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DW-1:0]     in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;
  logic                 rx_hold = 1'b0;

  // local copy of the block state
  logic [MAX_CELLS_DEF-1:0] ca_row;
  logic [GEN_W-1:0]         ca_gen;
  logic [RULE_W-1:0]        ca_rule;
  logic [BORDER_W-1:0]      ca_border;
  logic [HAB_W-1:0]         ca_hab;

  ca_result_t expected_results[$];
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int advance_count = 0;
  int reg_writes = 0;
  event long_hold_ev;

  elementary_cellular_automaton_step uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int cells_in_use();
    int n;
    n = int'(ca_hab);
    if (n == 0) n = 1;
    if (n > MAX_CELLS_DEF) n = MAX_CELLS_DEF;
    return n;
  endfunction

  task automatic predict_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                              input logic val, input logic [STEPS_W-1:0] steps,
                              output ca_result_t res);
    int n;
    logic [MAX_CELLS_DEF-1:0] nxt;
    logic left_pad, right_pad, l, r;
    n = cells_in_use();
    res.rd = 1'b0;
    case (op)
      OP_WRITE: if (idx < n) ca_row[idx] = val;
      OP_READ:  if (idx < n) res.rd = ca_row[idx];
      OP_ADVANCE: begin
        for (int s = 0; s < steps; s++) begin
          // outside neighbors; the unused border mode behaves as dead
          left_pad  = (ca_border == BORDER_WRAP) ? ca_row[n-1] : (ca_border == BORDER_ALIVE);
          right_pad = (ca_border == BORDER_WRAP) ? ca_row[0]   : (ca_border == BORDER_ALIVE);
          nxt = ca_row;
          for (int i = 0; i < n; i++) begin
            l = (i == 0)     ? left_pad  : ca_row[i-1];
            r = (i == n - 1) ? right_pad : ca_row[i+1];
            nxt[i] = ca_rule[{l, ca_row[i], r}];
          end
          ca_row = nxt;
          if (ca_gen != '1) ca_gen = ca_gen + 1;
        end
      end
      default: ;
    endcase
    res.gen = ca_gen;
  endtask

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic val, input logic [STEPS_W-1:0] steps,
                           input bit typed, input ca_result_t typed_res);
    ca_result_t res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'd0, steps, val, idx, op};
    do @(posedge clk); while (!in_tready);
    predict_item(op, idx, val, steps, res);
    expected_results.push_back(typed ? typed_res : res);
    items_sent++;
    if (op == OP_ADVANCE) advance_count++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DW-1:0] value);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_RULE:   ca_rule   = value[RULE_W-1:0];
      REG_BORDER: ca_border = value[BORDER_W-1:0];
      REG_HAB:    ca_hab    = value[HAB_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  function automatic dir_row_t item_row(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                        logic val, logic [STEPS_W-1:0] steps,
                                        bit typed = 1'b0, logic rd = 1'b0,
                                        logic [GEN_W-1:0] gen = '0);
    dir_row_t row;
    row.kind  = ROW_ITEM;
    row.op    = op;
    row.idx   = idx;
    row.val   = val;
    row.steps = steps;
    row.typed = typed;
    row.res   = '{rd: rd, gen: gen};
    row.sel   = '0;
    row.value = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] sel, logic [CFG_DW-1:0] value);
    dir_row_t row;
    row = item_row(OP_WRITE, '0, 1'b0, '0);
    row.kind  = ROW_CFG;
    row.sel   = sel;
    row.value = value;
    return row;
  endfunction

  // result side: check every delivered transaction, then pick next ready
  always @(posedge clk) begin
    ca_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: read %0b gen %0d", out_tdata[0], out_tdata[32:1]);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[0] !== want.rd || out_tdata[32:1] !== want.gen) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch on result %0d: expected read %0b gen %0d, got read %0b gen %0d",
                     results_seen, want.rd, want.gen, out_tdata[0], out_tdata[32:1]);
        end
      end
    end
    out_tready <= rx_hold ? 1'b0 : ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    forever begin
      @(long_hold_ev);
      repeat (LONG_HOLD) begin
        rx_hold <= 1'b1;
        @(posedge clk);
      end
      rx_hold <= 1'b0;
    end
  end

  initial begin
    #50_000_000;
    $display("tb_elementary_cellular_automaton_step: FAIL");
    $finish;
  end

  initial begin
    dir_row_t   directed_rows[$];
    phase_cfg_t phase_plan[$];
    phase_cfg_t pc;
    ca_result_t none;
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    logic [STEPS_W-1:0] steps;
    int pick, wait_cnt;

    ca_row    = '0;
    ca_gen    = '0;
    ca_rule   = RULE_RST;
    ca_border = BORDER_RST;
    ca_hab    = HAB_RST;
    none      = '0;

    directed_rows = '{
      // state right after reset
      item_row(OP_READ,    8'd0,   1'b0, 8'd0,   1, 1'b0, 32'd0),
      item_row(OP_READ,    8'd255, 1'b0, 8'd0,   1, 1'b0, 32'd0),
      item_row(OP_WRITE,   8'd0,   1'b1, 8'd0,   1, 1'b0, 32'd0),
      item_row(OP_WRITE,   8'd255, 1'b1, 8'd0,   1, 1'b0, 32'd0),
      item_row(OP_READ,    8'd255, 1'b0, 8'd0,   1, 1'b1, 32'd0),
      item_row(OP_READ,    8'd0,   1'b0, 8'd0,   1, 1'b1, 32'd0),
      // unused op and zero steps leave everything alone
      item_row(OP_UNUSED,  8'd0,   1'b1, 8'd255, 1, 1'b0, 32'd0),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd0,   1, 1'b0, 32'd0),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd1,   1, 1'b0, 32'd1),
      item_row(OP_READ,    8'd1,   1'b0, 8'd0),
      item_row(OP_READ,    8'd254, 1'b0, 8'd0),
      item_row(OP_WRITE,   8'd128, 1'b1, 8'd0,   1, 1'b0, 32'd1),
      item_row(OP_ADVANCE, 8'd255, 1'b1, 8'd255, 1, 1'b0, 32'd256),
      // size zero acts as a single cell that wraps onto itself
      cfg_row(REG_HAB, 9'd0),
      item_row(OP_WRITE,   8'd1,   1'b1, 8'd0,   1, 1'b0, 32'd256),
      item_row(OP_READ,    8'd1,   1'b0, 8'd0,   1, 1'b0, 32'd256),
      item_row(OP_WRITE,   8'd0,   1'b1, 8'd0,   1, 1'b0, 32'd256),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd1,   1, 1'b0, 32'd257),
      // size above the row length is clipped
      cfg_row(REG_HAB, 9'd300),
      item_row(OP_READ,    8'd255, 1'b0, 8'd0),
      // unused border mode with an all-alive rule
      cfg_row(REG_BORDER, {7'd0, BORDER_UNUSED}),
      cfg_row(REG_RULE, 9'd255),
      cfg_row(REG_HAB, 9'd3),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd1,   1, 1'b0, 32'd258),
      item_row(OP_READ,    8'd2,   1'b0, 8'd0,   1, 1'b1, 32'd258),
      item_row(OP_READ,    8'd3,   1'b0, 8'd0,   1, 1'b0, 32'd258),
      cfg_row(REG_RULE, 9'd0),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd2,   1, 1'b0, 32'd260),
      item_row(OP_READ,    8'd0,   1'b0, 8'd0,   1, 1'b0, 32'd260),
      cfg_row(REG_BORDER, {7'd0, BORDER_ALIVE}),
      cfg_row(REG_RULE, 9'd1),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd3),
      item_row(OP_READ,    8'd1,   1'b0, 8'd0),
      // grow back: cells outside the old size reappear
      cfg_row(REG_BORDER, {7'd0, BORDER_DEAD}),
      cfg_row(REG_RULE, 9'd90),
      cfg_row(REG_HAB, 9'd256),
      item_row(OP_READ,    8'd128, 1'b0, 8'd0),
      item_row(OP_ADVANCE, 8'd0,   1'b0, 8'd5),
      item_row(OP_READ,    8'd170, 1'b0, 8'd0)
    };

    phase_plan = '{
      '{8'd30,  BORDER_WRAP,   9'd256, 1'b0},
      '{8'd90,  BORDER_WRAP,   9'd16,  1'b0},
      '{8'd110, BORDER_DEAD,   9'd64,  1'b0},
      '{8'd184, BORDER_ALIVE,  9'd33,  1'b0},
      '{8'd0,   BORDER_DEAD,   9'd8,   1'b0},
      '{8'd255, BORDER_ALIVE,  9'd1,   1'b0},
      '{8'd150, BORDER_WRAP,   9'd1,   1'b0},
      '{8'd54,  BORDER_UNUSED, 9'd0,   1'b0},
      '{8'd45,  BORDER_WRAP,   9'd511, 1'b0},
      '{8'd73,  BORDER_DEAD,   9'd300, 1'b0},
      '{8'd105, BORDER_ALIVE,  9'd3,   1'b0},
      '{8'd30,  BORDER_DEAD,   9'd256, 1'b0},
      '{8'd0,   BORDER_WRAP,   9'd0,   1'b1}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG)
        write_reg(directed_rows[k].sel, directed_rows[k].value);
      else
        send_item(directed_rows[k].op, directed_rows[k].idx, directed_rows[k].val,
                  directed_rows[k].steps, directed_rows[k].typed, directed_rows[k].res);
    end

    foreach (phase_plan[p]) begin
      pc = phase_plan[p];
      if (pc.pick_random) begin
        pc.rule   = RULE_W'($urandom_range(0, 255));
        pc.border = BORDER_W'($urandom_range(0, 3));
        pc.hab    = HAB_W'($urandom_range(0, 511));
      end
      write_reg(REG_RULE, {1'b0, pc.rule});
      write_reg(REG_BORDER, {7'd0, pc.border});
      write_reg(REG_HAB, pc.hab);
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 56; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 56; end
        default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      if (p == 4) -> long_hold_ev;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 38)      op = OP_WRITE;
        else if (pick < 70) op = OP_READ;
        else if (pick < 93) op = OP_ADVANCE;
        else                op = OP_UNUSED;
        // mostly indexes inside the row, some anywhere
        if ($urandom_range(0, 99) < 80) idx = IDX_W'($urandom_range(0, cells_in_use() - 1));
        else                            idx = IDX_W'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (op != OP_ADVANCE) steps = STEPS_W'($urandom_range(0, 255));
        else if (pick < 80)   steps = STEPS_W'($urandom_range(1, 6));
        else if (pick < 92)   steps = STEPS_W'($urandom_range(7, 40));
        else if (pick < 96)   steps = 8'd0;
        else                  steps = STEPS_W'($urandom_range(41, 255));
        send_item(op, idx, 1'($urandom_range(0, 1)), steps, 1'b0, none);
      end
    end

    in_tvalid <= 1'b0;
    wait_cnt = 0;
    while (expected_results.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d transactions (%0d advances, %0d generations) and %0d results",
             items_sent, advance_count, ca_gen, results_seen);
    $display("across %0d register writes; %0d failures, %0d results never delivered",
             reg_writes, mismatch_count, expected_results.size());
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("tb_elementary_cellular_automaton_step: PASS");
    else
      $display("tb_elementary_cellular_automaton_step: FAIL");
    $finish;
  end

endmodule
